/* src/assert_macros.svh */
// Assertion macros shared by the RTL files.
// ASSERT_RST checks only while reset is released; ASSERT_ANY checks at every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_ANY(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ANY(lbl, clk, prop)
`endif
`endif

/* src/vna_pkg.sv */
package vna_pkg;

  localparam int unsigned MAX_VERTICES_DEF     = 4096;
  localparam int unsigned COORD_BITS_DEF       = 24;
  localparam int unsigned NORMAL_FRAC_BITS_DEF = 14;

  // Normal sums are always 64-bit signed.
  localparam int unsigned SUM_BITS = 64;
  localparam int unsigned OUT_BITS = 16;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_FACE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef struct packed {
    logic        [1:0]  cmd;
    logic        [11:0] vertex_a;
    logic        [11:0] corner_b;
    logic        [11:0] corner_c;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               zero_length;
    logic               saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CROSS,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_Q_RD,
    ST_Q_LAT,
    ST_NORM,
    ST_SQUARE,
    ST_SQRT,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

/* src/vna_ram.sv */
module vna_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [ADDR_W-1:0]        raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/vertex_normal_accumulator.sv */
// Area-weighted smooth vertex normal accumulator for one mesh.
//
// Input channel: an item is taken at a rising edge with start high and busy
// low. A load item stores one vertex and clears its normal sums and clip mark;
// busy never rises for it. A face item reads corners B, C and A from the vertex
// memory, forms the cross product of (B-C) and (B-A) on one shared multiplier,
// then reads, adds with saturation and writes back the sums of A, B and C in
// turn. A query item reads the sums, normalizes their magnitudes below 2^31 one
// bit per cycle, squares and sums them, takes an integer square root one result
// bit per cycle, then divides the three components on one shared restoring
// divider and presents the result. A query whose sums are all zero goes
// straight to the result, as does one with an out-of-range index.
// Result channel: out_valid is high for exactly one cycle with out_item; the
// receiver cannot stall, so no result is ever held back.
// Reset clears only the control state; the memories hold garbage until each
// entry is loaded, and no clearing pass runs.
`include "assert_macros.svh"

module vertex_normal_accumulator import vna_pkg::*; #(
  parameter int unsigned MAX_VERTICES     = MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS       = COORD_BITS_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int unsigned ADDR_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned DIFF_W  = COORD_BITS + 1;
  localparam int unsigned MUL_W   = (DIFF_W > 32) ? DIFF_W : 32;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned CROSS_W = 2 * DIFF_W + 1;
  localparam int unsigned SE_W    = ((CROSS_W > SUM_BITS) ? CROSS_W : SUM_BITS) + 1;
  localparam int unsigned QB      = NORMAL_FRAC_BITS + 1;
  localparam int unsigned VTX_W   = 3 * COORD_BITS;
  localparam int unsigned SUMS_W  = 3 * SUM_BITS + 1;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned REM_W   = 34;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       comp_r, comp_nxt;

  logic accept;
  logic a_ok, b_ok, c_ok;

  logic [ADDR_W-1:0] a_r, b_r, c_r;

  // Memory ports.
  logic              vtx_we, sum_we;
  logic [ADDR_W-1:0] vtx_raddr, sum_raddr, sum_waddr;
  logic [VTX_W-1:0]  vtx_wdata, vtx_rdata;
  logic [SUMS_W-1:0] sum_wdata, sum_rdata;

  // Face datapath.
  logic signed [COORD_BITS-1:0] vbx_r, vby_r, vbz_r, vcx_r, vcy_r, vcz_r;
  logic signed [COORD_BITS-1:0] rx, ry, rz;
  logic signed [DIFF_W-1:0]     u0_r, u1_r, u2_r, v0_r, v1_r, v2_r;
  logic signed [CROSS_W-1:0]    nx_r, ny_r, nz_r, prod_cross;
  logic signed [MUL_W-1:0]      op_a, op_b;
  logic signed [PROD_W-1:0]     prod_r;
  logic [CNT_W-1:0]             acc_step;

  logic signed [SUM_BITS-1:0] sx, sy, sz;
  logic                       sclip;
  logic [SUM_BITS:0]          add_x, add_y, add_z;

  // Query datapath.
  logic [SUM_BITS-1:0] m0_r, m1_r, m2_r;
  logic                sg0_r, sg1_r, sg2_r;
  logic [SUM_BITS-1:0] l2_r, sq_res_r, sq_bit_r, sq_try;
  logic [31:0]         len;
  logic [SUM_BITS-1:0] m_sel, dvd;
  logic                sg_sel;
  logic [REM_W-1:0]    rem_r, rem_try;
  logic [QB-1:0]       dlo_r, q_r, q_fin;
  logic                q_ge;
  logic [31:0]         q_ext, q_signed;
  out_item_t           out_r;
  logic                comps_zero;

  function automatic logic [SUM_BITS:0] sat_add(
    input logic signed [SUM_BITS-1:0] s,
    input logic signed [CROSS_W-1:0]  n
  );
    logic signed [SE_W-1:0] t;
    logic                   fits;
    t    = SE_W'(s) + SE_W'(n);
    fits = (&t[SE_W-1:SUM_BITS-1]) || !(|t[SE_W-1:SUM_BITS-1]);
    if (fits) begin
      sat_add = {1'b0, t[SUM_BITS-1:0]};
    end else if (t[SE_W-1]) begin
      sat_add = {1'b1, 1'b1, {(SUM_BITS-1){1'b0}}};
    end else begin
      sat_add = {1'b1, 1'b0, {(SUM_BITS-1){1'b1}}};
    end
  endfunction

  assign accept = start && !busy;
  assign a_ok   = 32'(in_item.vertex_a) < MAX_VERTICES;
  assign b_ok   = 32'(in_item.corner_b) < MAX_VERTICES;
  assign c_ok   = 32'(in_item.corner_c) < MAX_VERTICES;

  vna_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_vtx_ram (
    .clk   (clk),
    .we    (vtx_we),
    .waddr (ADDR_W'(in_item.vertex_a)),
    .wdata (vtx_wdata),
    .raddr (vtx_raddr),
    .rdata (vtx_rdata)
  );

  vna_ram #(.WIDTH(SUMS_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  assign vtx_wdata = {COORD_BITS'(in_item.coord_x), COORD_BITS'(in_item.coord_y),
                      COORD_BITS'(in_item.coord_z)};
  assign rx = vtx_rdata[VTX_W-1 -: COORD_BITS];
  assign ry = vtx_rdata[2*COORD_BITS-1 -: COORD_BITS];
  assign rz = vtx_rdata[COORD_BITS-1:0];

  // Stored word: clip mark on top, then the x, y and z sums.
  assign sclip = sum_rdata[SUMS_W-1];
  assign sx    = sum_rdata[3*SUM_BITS-1 -: SUM_BITS];
  assign sy    = sum_rdata[2*SUM_BITS-1 -: SUM_BITS];
  assign sz    = sum_rdata[SUM_BITS-1:0];

  assign add_x = sat_add(sx, nx_r);
  assign add_y = sat_add(sy, ny_r);
  assign add_z = sat_add(sz, nz_r);

  always_comb begin
    if (state_r == ST_ACC_WR) begin
      sum_wdata = {sclip | add_x[SUM_BITS] | add_y[SUM_BITS] | add_z[SUM_BITS],
                   add_x[SUM_BITS-1:0], add_y[SUM_BITS-1:0], add_z[SUM_BITS-1:0]};
    end else begin
      sum_wdata = '0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.cmd == CMD_FACE && a_ok && b_ok && c_ok) begin
            state_nxt = ST_FETCH;
          end else if (in_item.cmd == CMD_QUERY) begin
            state_nxt = a_ok ? ST_Q_RD : ST_OUT;
          end
        end
      end
      ST_FETCH:  if (cnt_r == CNT_W'(3)) state_nxt = ST_CROSS;
      ST_CROSS:  if (cnt_r == CNT_W'(6)) state_nxt = ST_ACC_RD;
      ST_ACC_RD: state_nxt = ST_ACC_WR;
      ST_ACC_WR: state_nxt = (comp_r == 2'd2) ? ST_IDLE : ST_ACC_RD;
      ST_Q_RD:   state_nxt = ST_Q_LAT;
      ST_Q_LAT:  state_nxt = (sx == '0 && sy == '0 && sz == '0) ? ST_OUT : ST_NORM;
      ST_NORM: begin
        if (!(|m0_r[SUM_BITS-1:31]) && !(|m1_r[SUM_BITS-1:31]) &&
            !(|m2_r[SUM_BITS-1:31])) begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: if (cnt_r == CNT_W'(3)) state_nxt = ST_SQRT;
      ST_SQRT:   if (cnt_r == CNT_W'(31)) state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == CNT_W'(QB) && comp_r == 2'd2) state_nxt = ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    vtx_we    = 1'b0;
    sum_we    = 1'b0;
    vtx_raddr = a_r;
    sum_raddr = a_r;
    sum_waddr = ADDR_W'(in_item.vertex_a);
    unique case (state_r)
      ST_IDLE: begin
        busy   = 1'b0;
        vtx_we = start && in_item.cmd == CMD_LOAD && a_ok;
        sum_we = start && in_item.cmd == CMD_LOAD && a_ok;
      end
      ST_FETCH: begin
        if (cnt_r == CNT_W'(0)) begin
          vtx_raddr = b_r;
        end else if (cnt_r == CNT_W'(1)) begin
          vtx_raddr = c_r;
        end
      end
      ST_ACC_RD: begin
        sum_raddr = (comp_r == 2'd0) ? a_r : ((comp_r == 2'd1) ? b_r : c_r);
      end
      ST_ACC_WR: begin
        sum_we    = 1'b1;
        sum_waddr = (comp_r == 2'd0) ? a_r : ((comp_r == 2'd1) ? b_r : c_r);
      end
      ST_OUT:  out_valid = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // Step counter restarts on every state change and per divided component.
  always_comb begin
    cnt_nxt  = cnt_r + CNT_W'(1);
    comp_nxt = comp_r;
    if (state_nxt != state_r || (state_r == ST_DIV && cnt_r == CNT_W'(QB))) begin
      cnt_nxt = '0;
    end
    if (state_r == ST_ACC_WR || (state_r == ST_DIV && cnt_r == CNT_W'(QB))) begin
      comp_nxt = comp_r + 2'd1;
    end
    if (state_r == ST_CROSS || state_r == ST_SQRT) begin
      comp_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      comp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      comp_r  <= comp_nxt;
    end
  end

  // Shared multiplier: cross product terms for faces, squares for queries.
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == ST_CROSS) begin
      case (cnt_r)
        CNT_W'(0): begin op_a = MUL_W'(u1_r); op_b = MUL_W'(v2_r); end
        CNT_W'(1): begin op_a = MUL_W'(u2_r); op_b = MUL_W'(v1_r); end
        CNT_W'(2): begin op_a = MUL_W'(u2_r); op_b = MUL_W'(v0_r); end
        CNT_W'(3): begin op_a = MUL_W'(u0_r); op_b = MUL_W'(v2_r); end
        CNT_W'(4): begin op_a = MUL_W'(u0_r); op_b = MUL_W'(v1_r); end
        CNT_W'(5): begin op_a = MUL_W'(u1_r); op_b = MUL_W'(v0_r); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end else if (state_r == ST_SQUARE) begin
      case (cnt_r)
        CNT_W'(0): begin
          op_a = MUL_W'($signed({1'b0, m0_r[30:0]}));
          op_b = MUL_W'($signed({1'b0, m0_r[30:0]}));
        end
        CNT_W'(1): begin
          op_a = MUL_W'($signed({1'b0, m1_r[30:0]}));
          op_b = MUL_W'($signed({1'b0, m1_r[30:0]}));
        end
        CNT_W'(2): begin
          op_a = MUL_W'($signed({1'b0, m2_r[30:0]}));
          op_b = MUL_W'($signed({1'b0, m2_r[30:0]}));
        end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end
  end

  assign prod_cross = CROSS_W'(prod_r);
  assign acc_step   = cnt_r - CNT_W'(1);

  // Square root and divider helpers.
  assign sq_try  = sq_res_r + sq_bit_r;
  assign len     = (sq_res_r == '0) ? 32'd1 : sq_res_r[31:0];
  assign m_sel   = (comp_r == 2'd0) ? m0_r : ((comp_r == 2'd1) ? m1_r : m2_r);
  assign sg_sel  = (comp_r == 2'd0) ? sg0_r : ((comp_r == 2'd1) ? sg1_r : sg2_r);
  assign dvd     = ({33'd0, m_sel[30:0]} << NORMAL_FRAC_BITS) + SUM_BITS'(len >> 1);
  assign rem_try = {rem_r[REM_W-2:0], dlo_r[QB-1]};
  assign q_ge    = rem_try >= {2'b00, len};
  assign q_fin   = {q_r[QB-2:0], q_ge};
  assign q_ext   = 32'(q_fin);
  assign q_signed = sg_sel ? (32'd0 - q_ext) : q_ext;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;

    if (state_r == ST_IDLE && accept) begin
      a_r <= ADDR_W'(in_item.vertex_a);
      b_r <= ADDR_W'(in_item.corner_b);
      c_r <= ADDR_W'(in_item.corner_c);
      if (in_item.cmd == CMD_QUERY && !a_ok) begin
        out_r <= '{normal_x: '0, normal_y: '0, normal_z: '0,
                   zero_length: 1'b1, saturated: 1'b0};
      end
    end

    if (state_r == ST_FETCH) begin
      if (cnt_r == CNT_W'(1)) begin
        vbx_r <= rx; vby_r <= ry; vbz_r <= rz;
      end else if (cnt_r == CNT_W'(2)) begin
        vcx_r <= rx; vcy_r <= ry; vcz_r <= rz;
      end else if (cnt_r == CNT_W'(3)) begin
        u0_r <= DIFF_W'(vbx_r) - DIFF_W'(vcx_r);
        u1_r <= DIFF_W'(vby_r) - DIFF_W'(vcy_r);
        u2_r <= DIFF_W'(vbz_r) - DIFF_W'(vcz_r);
        v0_r <= DIFF_W'(vbx_r) - DIFF_W'(rx);
        v1_r <= DIFF_W'(vby_r) - DIFF_W'(ry);
        v2_r <= DIFF_W'(vbz_r) - DIFF_W'(rz);
        nx_r <= '0;
        ny_r <= '0;
        nz_r <= '0;
      end
    end

    // The product of step k is registered in prod_r and added in the next cycle.
    if (state_r == ST_CROSS && cnt_r != CNT_W'(0)) begin
      case (acc_step)
        CNT_W'(0): nx_r <= nx_r + prod_cross;
        CNT_W'(1): nx_r <= nx_r - prod_cross;
        CNT_W'(2): ny_r <= ny_r + prod_cross;
        CNT_W'(3): ny_r <= ny_r - prod_cross;
        CNT_W'(4): nz_r <= nz_r + prod_cross;
        CNT_W'(5): nz_r <= nz_r - prod_cross;
        default: nx_r <= nx_r;
      endcase
    end

    if (state_r == ST_Q_LAT) begin
      m0_r  <= sx[SUM_BITS-1] ? (SUM_BITS'(0) - sx) : sx;
      m1_r  <= sy[SUM_BITS-1] ? (SUM_BITS'(0) - sy) : sy;
      m2_r  <= sz[SUM_BITS-1] ? (SUM_BITS'(0) - sz) : sz;
      sg0_r <= sx[SUM_BITS-1];
      sg1_r <= sy[SUM_BITS-1];
      sg2_r <= sz[SUM_BITS-1];
      l2_r     <= '0;
      sq_res_r <= '0;
      sq_bit_r <= SUM_BITS'(1) << (SUM_BITS - 2);
      out_r <= '{normal_x: '0, normal_y: '0, normal_z: '0,
                 zero_length: (sx == '0 && sy == '0 && sz == '0), saturated: sclip};
    end

    // Shift all magnitudes together until the largest is below 2^31.
    if (state_r == ST_NORM && state_nxt == ST_NORM) begin
      m0_r <= m0_r >> 1;
      m1_r <= m1_r >> 1;
      m2_r <= m2_r >> 1;
    end

    if (state_r == ST_SQUARE && cnt_r != CNT_W'(0)) begin
      l2_r <= l2_r + prod_r[SUM_BITS-1:0];
    end

    // One result bit per cycle; l2_r serves as the shrinking radicand.
    if (state_r == ST_SQRT) begin
      if (l2_r >= sq_try) begin
        l2_r     <= l2_r - sq_try;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end

    if (state_r == ST_DIV) begin
      if (cnt_r == CNT_W'(0)) begin
        rem_r <= REM_W'(dvd >> QB);
        dlo_r <= dvd[QB-1:0];
        q_r   <= '0;
      end else begin
        rem_r <= q_ge ? (rem_try - {2'b00, len}) : rem_try;
        dlo_r <= dlo_r << 1;
        q_r   <= q_fin;
        if (cnt_r == CNT_W'(QB)) begin
          case (comp_r)
            2'd0:    out_r.normal_x <= q_signed[OUT_BITS-1:0];
            2'd1:    out_r.normal_y <= q_signed[OUT_BITS-1:0];
            default: out_r.normal_z <= q_signed[OUT_BITS-1:0];
          endcase
        end
      end
    end
  end

  assign out_item = out_r;

  assign comps_zero = out_item.normal_x == '0 && out_item.normal_y == '0 &&
                      out_item.normal_z == '0;

  `ASSERT_ANY(a_strobe_busy, clk, out_valid |-> busy)
  `ASSERT_RST(a_strobe_single, clk, rst_n, out_valid |=> !out_valid)
  `ASSERT_RST(a_wr_after_rd, clk, rst_n, (state_r == ST_ACC_WR) |-> ($past(state_r) == ST_ACC_RD))
  `ASSERT_RST(a_zero_clean, clk, rst_n, (out_valid && out_item.zero_length) |-> comps_zero)

endmodule
